### design/ppo_pkg.sv
// shared types, widths and register indexes for the perspective projection block
// used by every module of the design; no dependencies
`default_nettype none
package ppo_pkg;

  localparam int VEC_BITS_DEF    = 16;
  localparam int SCREEN_BITS_DEF = 12;

  localparam int ENT_W  = 16;   // matrix entry and reduced vector width
  localparam int ROW_W  = 48;
  localparam int SCL_W  = 24;
  localparam int PROD_W = 32;
  localparam int SUM_W  = 34;   // dot product, room for three terms
  localparam int NUM_W  = 61;   // signed numerator
  localparam int MAG_W  = 60;   // numerator magnitude
  localparam int DEN_W  = 43;   // |512 * d|
  localparam int Q_W    = 17;   // quotient bits kept before saturation
  localparam int POS_W  = 16;
  localparam int CFG_IDX_W = 3;

  localparam int DOT_STAGES = 2;
  localparam int NUM_STAGES = 3;
  localparam int DIV_STAGES = Q_W + 1;
  localparam int N_STAGES   = DOT_STAGES + NUM_STAGES + DIV_STAGES + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAT_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAT_ROW1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAT_ROW2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_W    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_H    = 3'd6;

  localparam logic [3:0] OC_LEFT   = 4'b1000;
  localparam logic [3:0] OC_RIGHT  = 4'b0100;
  localparam logic [3:0] OC_ABOVE  = 4'b0010;
  localparam logic [3:0] OC_BELOW  = 4'b0001;
  localparam logic [3:0] OC_BEHIND = 4'b1111;

  typedef struct packed {
    logic sign_x;
    logic sign_y;
    logic behind;
    logic dzero;
  } sb_t;

endpackage
`default_nettype wire

### design/point_perspective_project_outcode.sv
// top level of the perspective projection with screen outcodes
// depends on ppo_pkg, ppo_dot, ppo_num and ppo_div
//
// usage
//   a request on in_ carries one direction vector; it is taken at a clock
//   edge with in_valid high and in_stall low. each request gives exactly one
//   result on out_, taken at an edge with out_valid high and out_stall low.
//   camera matrix rows, focal scales and screen size are written on the cfg_
//   channel (cfg_ready is always high) while no request is in flight.
// pipeline and throughput
//   24 register stages: 2 for the matrix product, 3 for the numerators and
//   magnitudes, 18 for the divider (range check plus one quotient bit per
//   stage) and the output register. one request per cycle unless stalled.
// stalls
//   each stage holds its valid bit and moves when the next one is empty or
//   moving, so bubbles close up and the pipe keeps taking requests while a
//   result waits; in_stall rises only when all 24 stages hold data.
// reset
//   synchronous, active low: all valid bits clear, matrix and scales go to
//   zero, screen size goes to 320 by 240.
`default_nettype none
module point_perspective_project_outcode #(
  parameter int VEC_BITS    = ppo_pkg::VEC_BITS_DEF,
  parameter int SCREEN_BITS = ppo_pkg::SCREEN_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [VEC_BITS-1:0]         in_vec_x,
  input  wire logic signed [VEC_BITS-1:0]         in_vec_y,
  input  wire logic signed [VEC_BITS-1:0]         in_vec_z,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [ppo_pkg::POS_W-1:0]        out_x_pos,
  output logic signed [ppo_pkg::POS_W-1:0]        out_y_pos,
  output logic                                    out_behind,
  output logic [3:0]                              out_outcode,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ppo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ppo_pkg::ROW_W-1:0]          cfg_data
);

  localparam int NS      = ppo_pkg::N_STAGES;
  localparam int NUM_LO  = ppo_pkg::DOT_STAGES;
  localparam int DIV_LO  = NUM_LO + ppo_pkg::NUM_STAGES;
  localparam int ND      = ppo_pkg::DIV_STAGES;
  localparam int OUT_S   = NS - 1;

  // configuration registers
  logic [ppo_pkg::ROW_W-1:0]  row0_r, row1_r, row2_r;
  logic [ppo_pkg::SCL_W-1:0]  scale_x_r, scale_y_r;
  logic [SCREEN_BITS-1:0]     scr_w_r, scr_h_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r    <= '0;
      row1_r    <= '0;
      row2_r    <= '0;
      scale_x_r <= '0;
      scale_y_r <= '0;
      scr_w_r   <= SCREEN_BITS'(320);
      scr_h_r   <= SCREEN_BITS'(240);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppo_pkg::CFG_MAT_ROW0: row0_r    <= cfg_data;
        ppo_pkg::CFG_MAT_ROW1: row1_r    <= cfg_data;
        ppo_pkg::CFG_MAT_ROW2: row2_r    <= cfg_data;
        ppo_pkg::CFG_SCALE_X:  scale_x_r <= cfg_data[ppo_pkg::SCL_W-1:0];
        ppo_pkg::CFG_SCALE_Y:  scale_y_r <= cfg_data[ppo_pkg::SCL_W-1:0];
        ppo_pkg::CFG_SCR_W:    scr_w_r   <= cfg_data[SCREEN_BITS-1:0];
        ppo_pkg::CFG_SCR_H:    scr_h_r   <= cfg_data[SCREEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // valid bits and per-stage advance
  logic [NS-1:0] vld_r;
  logic [NS-1:0] en;

  always_comb begin
    en[OUT_S] = !vld_r[OUT_S] || !out_stall;
    for (int k = OUT_S - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // matrix product
  logic signed [ppo_pkg::SUM_W-1:0] vx, vy, dd;

  ppo_dot #(.VEC_BITS(VEC_BITS)) u_dot (
    .clk   (clk),
    .en    (en[NUM_LO-1:0]),
    .vec_x (in_vec_x),
    .vec_y (in_vec_y),
    .vec_z (in_vec_z),
    .row0  (row0_r),
    .row1  (row1_r),
    .row2  (row2_r),
    .vx    (vx),
    .vy    (vy),
    .d     (dd)
  );

  // numerators, denominator and signs
  logic [ppo_pkg::MAG_W-1:0] nmag_x, nmag_y;
  logic [ppo_pkg::DEN_W-1:0] dmag;
  ppo_pkg::sb_t              sb;

  ppo_num #(.SCREEN_BITS(SCREEN_BITS)) u_num (
    .clk     (clk),
    .en      (en[DIV_LO-1:NUM_LO]),
    .vx      (vx),
    .vy      (vy),
    .d       (dd),
    .scale_x (scale_x_r),
    .scale_y (scale_y_r),
    .scr_w   (scr_w_r),
    .scr_h   (scr_h_r),
    .nmag_x  (nmag_x),
    .nmag_y  (nmag_y),
    .dmag    (dmag),
    .sb      (sb)
  );

  // one divider per axis, signs ride alongside
  logic [ppo_pkg::Q_W-1:0] qx, qy;
  logic                    ovfx, ovfy;
  ppo_pkg::sb_t            sb_r [ND];

  ppo_div u_div_x (
    .clk (clk),
    .en  (en[OUT_S-1:DIV_LO]),
    .num (nmag_x),
    .den (dmag),
    .quo (qx),
    .ovf (ovfx)
  );

  ppo_div u_div_y (
    .clk (clk),
    .en  (en[OUT_S-1:DIV_LO]),
    .num (nmag_y),
    .den (dmag),
    .quo (qy),
    .ovf (ovfy)
  );

  always_ff @(posedge clk) begin
    if (en[DIV_LO]) begin
      sb_r[0] <= sb;
    end
    for (int j = 1; j < ND; j++) begin
      if (en[DIV_LO+j]) begin
        sb_r[j] <= sb_r[j-1];
      end
    end
  end

  // signed placement, outcode bits from the unsaturated value
  ppo_pkg::sb_t sbf;
  logic                              x_lt0, x_ge, y_lt0, y_ge;
  logic signed [ppo_pkg::POS_W-1:0]  x_nxt, y_nxt;
  logic [3:0]                        code_nxt;
  localparam logic [ppo_pkg::Q_W-1:0] Q_POS_MAX = ppo_pkg::Q_W'(32767);
  localparam logic [ppo_pkg::Q_W-1:0] Q_NEG_MAX = ppo_pkg::Q_W'(32768);

  assign sbf   = sb_r[ND-1];
  assign x_lt0 = sbf.sign_x && (ovfx || (qx != '0));
  assign y_lt0 = sbf.sign_y && (ovfy || (qy != '0));
  assign x_ge  = !x_lt0 && (ovfx || (qx >= ppo_pkg::Q_W'(scr_w_r)));
  assign y_ge  = !y_lt0 && (ovfy || (qy >= ppo_pkg::Q_W'(scr_h_r)));

  always_comb begin
    if (sbf.dzero) begin
      x_nxt = '0;
    end else if (x_lt0) begin
      x_nxt = (ovfx || qx >= Q_NEG_MAX) ? -ppo_pkg::POS_W'(32768)
                                        : -$signed(qx[ppo_pkg::POS_W-1:0]);
    end else begin
      x_nxt = (ovfx || qx > Q_POS_MAX) ? ppo_pkg::POS_W'(32767)
                                       : $signed(qx[ppo_pkg::POS_W-1:0]);
    end
    if (sbf.dzero) begin
      y_nxt = '0;
    end else if (y_lt0) begin
      y_nxt = (ovfy || qy >= Q_NEG_MAX) ? -ppo_pkg::POS_W'(32768)
                                        : -$signed(qy[ppo_pkg::POS_W-1:0]);
    end else begin
      y_nxt = (ovfy || qy > Q_POS_MAX) ? ppo_pkg::POS_W'(32767)
                                       : $signed(qy[ppo_pkg::POS_W-1:0]);
    end
    if (sbf.behind) begin
      code_nxt = ppo_pkg::OC_BEHIND;
    end else begin
      code_nxt = (x_lt0 ? ppo_pkg::OC_LEFT : 4'b0) | (x_ge ? ppo_pkg::OC_RIGHT : 4'b0)
               | (y_lt0 ? ppo_pkg::OC_ABOVE : 4'b0) | (y_ge ? ppo_pkg::OC_BELOW : 4'b0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[OUT_S]) begin
      out_x_pos   <= x_nxt;
      out_y_pos   <= y_nxt;
      out_behind  <= sbf.behind;
      out_outcode <= code_nxt;
    end
  end

  assign out_valid = vld_r[OUT_S];

endmodule
`default_nettype wire

### design/ppo_dot.sv
// matrix times vector: one stage of products, one stage of sums
// depends on ppo_pkg
`default_nettype none
module ppo_dot #(
  parameter int VEC_BITS = ppo_pkg::VEC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic [1:0]                        en,
  input  wire logic signed [VEC_BITS-1:0]        vec_x,
  input  wire logic signed [VEC_BITS-1:0]        vec_y,
  input  wire logic signed [VEC_BITS-1:0]        vec_z,
  input  wire logic [ppo_pkg::ROW_W-1:0]         row0,
  input  wire logic [ppo_pkg::ROW_W-1:0]         row1,
  input  wire logic [ppo_pkg::ROW_W-1:0]         row2,
  output logic signed [ppo_pkg::SUM_W-1:0]       vx,
  output logic signed [ppo_pkg::SUM_W-1:0]       vy,
  output logic signed [ppo_pkg::SUM_W-1:0]       d
);

  logic signed [VEC_BITS-1:0]         vraw [3];
  logic signed [ppo_pkg::ENT_W-1:0]   vin  [3];
  logic [ppo_pkg::ROW_W-1:0]          rows [3];
  logic signed [ppo_pkg::PROD_W-1:0]  prod_r [9];

  assign vraw[0] = vec_x;
  assign vraw[1] = vec_y;
  assign vraw[2] = vec_z;
  assign rows[0] = row0;
  assign rows[1] = row1;
  assign rows[2] = row2;

  // wide vectors keep their top 16 bits, truncated toward zero
  generate
    if (VEC_BITS > ppo_pkg::ENT_W) begin : g_reduce
      localparam int SH = VEC_BITS - ppo_pkg::ENT_W;
      for (genvar k = 0; k < 3; k++) begin : g_comp
        logic signed [VEC_BITS-1:0] sh;
        logic                       adj;
        assign sh     = vraw[k] >>> SH;
        assign adj    = vraw[k][VEC_BITS-1] && (|vraw[k][SH-1:0]);
        assign vin[k] = sh[ppo_pkg::ENT_W-1:0] + {{(ppo_pkg::ENT_W-1){1'b0}}, adj};
      end
    end else begin : g_ext
      for (genvar k = 0; k < 3; k++) begin : g_comp
        assign vin[k] = ppo_pkg::ENT_W'(vraw[k]);
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_r[3*r+k] <= $signed(rows[r][16*k +: 16]) * vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      vx <= ppo_pkg::SUM_W'(prod_r[0]) + ppo_pkg::SUM_W'(prod_r[1])
          + ppo_pkg::SUM_W'(prod_r[2]);
      vy <= ppo_pkg::SUM_W'(prod_r[3]) + ppo_pkg::SUM_W'(prod_r[4])
          + ppo_pkg::SUM_W'(prod_r[5]);
      d  <= ppo_pkg::SUM_W'(prod_r[6]) + ppo_pkg::SUM_W'(prod_r[7])
          + ppo_pkg::SUM_W'(prod_r[8]);
    end
  end

endmodule
`default_nettype wire

### design/ppo_num.sv
// numerator and denominator of the screen placement, turned to magnitudes
// depends on ppo_pkg
`default_nettype none
module ppo_num #(
  parameter int SCREEN_BITS = ppo_pkg::SCREEN_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic [2:0]                    en,
  input  wire logic signed [ppo_pkg::SUM_W-1:0] vx,
  input  wire logic signed [ppo_pkg::SUM_W-1:0] vy,
  input  wire logic signed [ppo_pkg::SUM_W-1:0] d,
  input  wire logic [ppo_pkg::SCL_W-1:0]     scale_x,
  input  wire logic [ppo_pkg::SCL_W-1:0]     scale_y,
  input  wire logic [SCREEN_BITS-1:0]        scr_w,
  input  wire logic [SCREEN_BITS-1:0]        scr_h,
  output logic [ppo_pkg::MAG_W-1:0]          nmag_x,
  output logic [ppo_pkg::MAG_W-1:0]          nmag_y,
  output logic [ppo_pkg::DEN_W-1:0]          dmag,
  output ppo_pkg::sb_t                       sb
);

  localparam int P1_W = ppo_pkg::SUM_W + ppo_pkg::SCL_W + 1;
  localparam int P2_W = ppo_pkg::SUM_W + SCREEN_BITS + 1;

  logic signed [P1_W-1:0] p1x_r, p1y_r;
  logic signed [P2_W-1:0] p2x_r, p2y_r;
  logic signed [ppo_pkg::SUM_W-1:0] d2_r, d3_r;
  logic signed [ppo_pkg::NUM_W-1:0] numx_r, numy_r;
  logic [ppo_pkg::SUM_W-1:0] dabs;

  // n * scale and size * d
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1x_r <= vx * $signed({1'b0, scale_x});
      p1y_r <= vy * $signed({1'b0, scale_y});
      p2x_r <= d * $signed({1'b0, scr_w});
      p2y_r <= d * $signed({1'b0, scr_h});
      d2_r  <= d;
    end
  end

  // num = size*256*d - 2*n*scale
  always_ff @(posedge clk) begin
    if (en[1]) begin
      numx_r <= (ppo_pkg::NUM_W'(p2x_r) <<< 8) - (ppo_pkg::NUM_W'(p1x_r) <<< 1);
      numy_r <= (ppo_pkg::NUM_W'(p2y_r) <<< 8) - (ppo_pkg::NUM_W'(p1y_r) <<< 1);
      d3_r   <= d2_r;
    end
  end

  assign dabs = d3_r[ppo_pkg::SUM_W-1] ? ppo_pkg::SUM_W'(-d3_r) : ppo_pkg::SUM_W'(d3_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      nmag_x    <= numx_r[ppo_pkg::NUM_W-1] ? ppo_pkg::MAG_W'(-numx_r)
                                            : ppo_pkg::MAG_W'(numx_r);
      nmag_y    <= numy_r[ppo_pkg::NUM_W-1] ? ppo_pkg::MAG_W'(-numy_r)
                                            : ppo_pkg::MAG_W'(numy_r);
      dmag      <= {dabs, 9'b0};
      sb.sign_x <= numx_r[ppo_pkg::NUM_W-1] ^ d3_r[ppo_pkg::SUM_W-1];
      sb.sign_y <= numy_r[ppo_pkg::NUM_W-1] ^ d3_r[ppo_pkg::SUM_W-1];
      sb.behind <= !d3_r[ppo_pkg::SUM_W-1];
      sb.dzero  <= (d3_r == '0);
    end
  end

endmodule
`default_nettype wire

### design/ppo_div.sv
// pipelined restoring divider: range check stage, then one quotient bit a stage
// depends on ppo_pkg
`default_nettype none
module ppo_div (
  input  wire logic                               clk,
  input  wire logic [ppo_pkg::DIV_STAGES-1:0]     en,
  input  wire logic [ppo_pkg::MAG_W-1:0]          num,
  input  wire logic [ppo_pkg::DEN_W-1:0]          den,
  output logic [ppo_pkg::Q_W-1:0]                 quo,
  output logic                                    ovf
);

  localparam int NS = ppo_pkg::DIV_STAGES;

  logic [ppo_pkg::MAG_W-1:0] rem_r [NS];
  logic [ppo_pkg::DEN_W-1:0] den_r [NS];
  logic [ppo_pkg::Q_W-1:0]   q_r   [NS];
  logic                      ovf_r [NS];

  // quotient of 2^17 or more only saturates
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= num >= (ppo_pkg::MAG_W'(den) << ppo_pkg::Q_W);
    end
  end

  generate
    for (genvar j = 1; j < NS; j++) begin : g_bit
      localparam int B = ppo_pkg::Q_W - j;
      logic [ppo_pkg::MAG_W-1:0] sub;
      logic                      hit;
      assign sub = ppo_pkg::MAG_W'(den_r[j-1]) << B;
      assign hit = rem_r[j-1] >= sub;
      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem_r[j] <= hit ? rem_r[j-1] - sub : rem_r[j-1];
          den_r[j] <= den_r[j-1];
          q_r[j]   <= q_r[j-1] | (hit ? (ppo_pkg::Q_W'(1) << B) : '0);
          ovf_r[j] <= ovf_r[j-1];
        end
      end
    end
  endgenerate

  assign quo = q_r[NS-1];
  assign ovf = ovf_r[NS-1];

endmodule
`default_nettype wire
